>>> rtl/bsrm_pkg.sv
// shared types and constants for the backing store range map
// operation codes, request and token structs, parameter defaults
// no dependencies
package bsrm_pkg;

  localparam int NUM_PROCS_DEF  = 32;
  localparam int NUM_STORES_DEF = 8;

  localparam int PAGE_W    = 20;
  localparam int PID_W_IN  = 5;
  localparam int SEL_W     = 3;
  localparam int PID_IDX_W = 8;

  typedef enum logic [1:0] {
    OP_GET_FREE = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_MAP      = 2'd2,
    OP_UNMAP    = 2'd3
  } op_t;

  // request as seen on the accept edge: read and map write
  typedef struct packed {
    logic                 en;
    op_t                  op;
    logic [PID_IDX_W-1:0] pid;
    logic                 pid_ok;
    logic [SEL_W-1:0]     sel;
    logic [PAGE_W-1:0]    page;
    logic [PAGE_W-1:0]    count;
  } acc_t;

  // request held while the token walks the chain
  typedef struct packed {
    op_t                  op;
    logic [PID_IDX_W-1:0] pid;
    logic                 pid_ok;
    logic [PAGE_W-1:0]    page;
  } run_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              live;
    logic              hit;
    logic [SEL_W-1:0]  idx;
    logic [PAGE_W-1:0] off;
  } tok_t;

  // per-process mapping held in each cell's memory
  typedef struct packed {
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] count;
  } ent_t;

endpackage

>>> rtl/bsrm_cell.sv
// one backing store: in-use mark, per-process valid bits and mapping memory
// takes the token from its lower neighbour and hands it on each cycle
// depends on bsrm_pkg
module bsrm_cell #(
  parameter int NUM_PROCS = 32,
  parameter int IDX       = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bsrm_pkg::acc_t acc,
  input  bsrm_pkg::run_t run,
  input  bsrm_pkg::tok_t tok_in,
  output bsrm_pkg::tok_t tok_out
);
  import bsrm_pkg::*;

  localparam int PID_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  logic                 in_use_r;
  logic [NUM_PROCS-1:0] valid_r;
  ent_t                 mem [NUM_PROCS];
  ent_t                 rd_r;
  logic                 vld_rd_r;
  tok_t                 tok_r;

  logic [PID_W-1:0]  acc_idx;
  logic [PID_W-1:0]  run_idx;
  logic              map_here;
  logic              in_range;
  logic [PAGE_W:0]   range_end;
  logic              match;
  logic              take;
  tok_t              tok_nxt;

  assign acc_idx  = acc.pid[PID_W-1:0];
  assign run_idx  = run.pid[PID_W-1:0];
  assign map_here = acc.en && (acc.op == OP_MAP) && acc.pid_ok && (32'(acc.sel) == IDX);

  // range end without wrap
  assign range_end = {1'b0, rd_r.base} + {1'b0, rd_r.count};
  assign in_range  = (rd_r.base <= run.page) && ({1'b0, run.page} < range_end);

  always_comb begin
    case (run.op)
      OP_GET_FREE: match = !in_use_r;
      OP_LOOKUP,
      OP_UNMAP:    match = run.pid_ok && in_use_r && vld_rd_r && in_range;
      default:     match = 1'b0;
    endcase
  end

  assign take = !tok_in.hit && match;

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = SEL_W'(IDX);
      tok_nxt.off = (run.op == OP_GET_FREE) ? '0 : run.page - rd_r.base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      valid_r  <= '0;
      tok_r    <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (map_here) begin
        in_use_r         <= 1'b1;
        valid_r[acc_idx] <= 1'b1;
      end else if (tok_in.live && take && (run.op == OP_UNMAP)) begin
        valid_r[run_idx] <= 1'b0;
      end
    end
  end

  // mapping memory, registered read on the accept edge
  always_ff @(posedge clk) begin
    if (map_here) begin
      mem[acc_idx] <= '{base: acc.page, count: acc.count};
    end
    if (acc.en && acc.pid_ok) begin
      rd_r     <= mem[acc_idx];
      vld_rd_r <= valid_r[acc_idx];
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/backing_store_range_map.sv
// Backing store range map. One item is taken at a time; a new input beat
// is taken only once the previous result has moved into the output
// register. The result waits on the chain of store cells: on the accept
// edge every cell reads its mapping for the process, then a search token
// walks the chain, one cell per cycle, lowest store first, so the first
// hit wins. The result register parts the output from the chain, so an
// item may be accepted while an earlier result beat is still stalled. A
// store once mapped never becomes free again. No clearing pass: reset
// clears the in-use marks and mapping valid bits at once.
// depends on bsrm_pkg and bsrm_cell
module backing_store_range_map #(
  parameter int NUM_PROCS  = bsrm_pkg::NUM_PROCS_DEF,
  parameter int NUM_STORES = bsrm_pkg::NUM_STORES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [bsrm_pkg::PID_W_IN-1:0] in_process_id,
  input  logic [bsrm_pkg::PAGE_W-1:0] in_virtual_page,
  input  logic [bsrm_pkg::SEL_W-1:0]  in_store_select,
  input  logic [bsrm_pkg::PAGE_W-1:0] in_page_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [bsrm_pkg::SEL_W-1:0]  out_store_index,
  output logic [bsrm_pkg::PAGE_W-1:0] out_page_offset
);
  import bsrm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic in_accept;
  logic pid_ok;
  acc_t acc;
  run_t run_r;
  logic start_r;
  logic map_ok_r;
  logic load_out;

  // held result between chain end and output register
  logic              res_status_r;
  logic [SEL_W-1:0]  res_idx_r;
  logic [PAGE_W-1:0] res_off_r;

  logic              out_valid_r;
  logic              out_status_r;
  logic [SEL_W-1:0]  out_idx_r;
  logic [PAGE_W-1:0] out_off_r;

  tok_t tok [NUM_STORES+1];
  tok_t last;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign pid_ok    = (32'(in_process_id) < NUM_PROCS);

  always_comb begin
    acc        = '0;
    acc.en     = in_accept;
    acc.op     = op_t'(in_operation);
    acc.pid    = PID_IDX_W'(in_process_id);
    acc.pid_ok = pid_ok;
    acc.sel    = in_store_select;
    acc.page   = in_virtual_page;
    acc.count  = in_page_count;
  end

  // chain entry: empty token, live for one cycle after the accept beat
  always_comb begin
    tok[0]      = '0;
    tok[0].live = start_r;
  end

  for (genvar g = 0; g < NUM_STORES; g++) begin : g_cell
    bsrm_cell #(
      .NUM_PROCS (NUM_PROCS),
      .IDX       (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .acc     (acc),
      .run     (run_r),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign last     = tok[NUM_STORES];
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_RUN;
      ST_RUN:  if (last.live) state_nxt = ST_DONE;
      ST_DONE: if (load_out)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_accept;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      run_r.op     <= acc.op;
      run_r.pid    <= acc.pid;
      run_r.pid_ok <= pid_ok;
      run_r.page   <= in_virtual_page;
      map_ok_r     <= pid_ok && (32'(in_store_select) < NUM_STORES);
    end
    if ((state_r == ST_RUN) && last.live) begin
      // map reports only its range check; the others report the search
      if (run_r.op == OP_MAP) begin
        res_status_r <= !map_ok_r;
        res_idx_r    <= '0;
        res_off_r    <= '0;
      end else begin
        res_status_r <= !last.hit;
        res_idx_r    <= last.hit ? last.idx : '0;
        res_off_r    <= last.hit ? last.off : '0;
      end
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_off_r    <= res_off_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_store_index = out_idx_r;
  assign out_page_offset = out_off_r;

endmodule
